// ===== rtl/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared constants, types and small tables for the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ecal_pkg;

	// field widths
	localparam int SECS_W   = 32;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int WDAY_W   = 3;
	localparam int SOD_W    = 17;
	localparam int DAYS_W   = 16;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_LOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_HIGH = 1'd1;

	localparam logic [CFG_W-1:0] YEAR_LOW_RST  = 12'd2015;
	localparam logic [CFG_W-1:0] YEAR_HIGH_RST = 12'd2025;

	// pipeline stages ahead of the output register
	localparam int NUM_STG = 6;

	// reciprocal multipliers, each exact over the operand range it sees
	localparam logic [25:0] RCP_675  = 26'd50903317; // x < 2^25, shift 35
	localparam logic [16:0] RCP_7    = 17'd74899;    // x < 2^16, shift 19
	localparam logic [13:0] RCP_225  = 14'd9321;     // x < 2^13, shift 21
	localparam logic [16:0] RCP_1461 = 17'd91868;    // x < 2^16, shift 27
	localparam logic [10:0] RCP_15   = 11'd1093;     // x < 2^10, shift 14
	localparam logic [11:0] RCP_153  = 12'd3427;     // x < 2^11, shift 19

	// day counts taken from 1968-03-01 (start of a four-year cycle)
	localparam logic [DAYS_W-1:0] MAR_BASE_OFS = 16'd671;   // 1968-03-01 .. 1970-01-01
	localparam logic [DAYS_W-1:0] MAR_2100     = 16'd48212; // 1968-03-01 .. 2100-03-01
	localparam logic [YEAR_W-1:0] MAR_BASE_YR  = 12'd1968;
	localparam logic [2:0]        EPOCH_WDAY   = 3'd4;      // 1970-01-01 was a Thursday

	typedef struct packed {
		logic [NUM_STG:1] ld; // stage register may load this cycle
	} ecal_ctl_t;

	// first day (March-based day of year) of month index mp, March = 0
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ecal_tod.sv =====
// ----------------------------------------------------------------------------
// ecal_tod
// Time-of-day lane: second of day, then hour, minute and second.
// ----------------------------------------------------------------------------
module ecal_tod
	import ecal_pkg::*;
(
	input  logic              clk,
	input  ecal_ctl_t         ctl,
	input  logic [SECS_W-1:0] secs_s1,
	input  logic [DAYS_W-1:0] days_s1,
	output logic [SOD_W-1:0]  sod_s6,
	output logic [HOUR_W-1:0] hour_s6,
	output logic [MIN_W-1:0]  minute_s6,
	output logic [SEC_W-1:0]  second_s6
);

	logic [32:0]       day_secs;
	logic [SECS_W-1:0] sod_full;
	logic [26:0]       hr_prod;
	logic [SOD_W-1:0]  rem_full;
	logic [20:0]       mn_prod;
	logic [11:0]       mn_secs;
	logic [11:0]       sc_full;

	logic [SOD_W-1:0]  sod_s2, sod_s3, sod_s4, sod_s5;
	logic [HOUR_W-1:0] hour_s3, hour_s4, hour_s5;
	logic [11:0]       rem_s4, rem_s5;
	logic [MIN_W-1:0]  minute_s5;

	// S2: remainder of the day split
	assign day_secs = 33'(days_s1) * 33'd86400;
	assign sod_full = secs_s1 - day_secs[31:0];

	// S3: hour = (sod/16)/225
	assign hr_prod = 27'(sod_s2[16:4]) * 27'(RCP_225);

	// S4: seconds within the hour
	assign rem_full = sod_s3 - 17'(hour_s3) * 17'd3600;

	// S5: minute = (rem/4)/15
	assign mn_prod = 21'(rem_s4[11:2]) * 21'(RCP_15);

	// S6: second
	assign mn_secs = 12'(minute_s5) * 12'd60;
	assign sc_full = rem_s5 - mn_secs;

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			sod_s2 <= sod_full[SOD_W-1:0];
		end
		if (ctl.ld[3]) begin
			sod_s3  <= sod_s2;
			hour_s3 <= hr_prod[25:21];
		end
		if (ctl.ld[4]) begin
			sod_s4  <= sod_s3;
			hour_s4 <= hour_s3;
			rem_s4  <= rem_full[11:0];
		end
		if (ctl.ld[5]) begin
			sod_s5    <= sod_s4;
			hour_s5   <= hour_s4;
			rem_s5    <= rem_s4;
			minute_s5 <= mn_prod[19:14];
		end
		if (ctl.ld[6]) begin
			sod_s6    <= sod_s5;
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			second_s6 <= sc_full[SEC_W-1:0];
		end
	end

endmodule

// ===== rtl/ecal_date.sv =====
// ----------------------------------------------------------------------------
// ecal_date
// Date lane: day count to year, month, day of month and weekday.
// ----------------------------------------------------------------------------
module ecal_date
	import ecal_pkg::*;
(
	input  logic               clk,
	input  ecal_ctl_t          ctl,
	input  logic [DAYS_W-1:0]  days_s1,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [MDAY_W-1:0]  day_of_month,
	output logic [WDAY_W-1:0]  weekday_s6
);

	logic [DAYS_W-1:0] days4;
	logic [32:0]       wq_prod;
	logic [DAYS_W-1:0] zp_full;
	logic [DAYS_W-1:0] wk_full;
	logic [32:0]       cy_prod;
	logic [DAYS_W-1:0] r_full;
	logic [1:0]        yoc;
	logic [10:0]       doy_full;
	logic [10:0]       mp_arg;
	logic [22:0]       mp_prod;
	logic [8:0]        mday_full;

	logic [DAYS_W-1:0] days4_s2, zp_s2, zp_s3;
	logic [12:0]       wq_s2;
	logic [WDAY_W-1:0] weekday_s3, weekday_s4, weekday_s5;
	logic [5:0]        cyc_s3, cyc_s4;
	logic [10:0]       r_s4;
	logic [8:0]        doy_s5, doy_s6;
	logic [YEAR_W-1:0] ymar_s5, ymar_s6;
	logic [3:0]        mp_s6;

	// S2: weekday quotient; March-based day count, with a phantom 2100-02-29
	// so every four-year cycle is 1461 days
	assign days4   = days_s1 + 16'(EPOCH_WDAY);
	assign wq_prod = 33'(days4) * 33'(RCP_7);
	assign zp_full = days_s1 + MAR_BASE_OFS
		+ 16'(days_s1 + MAR_BASE_OFS >= MAR_2100);

	// S3: cycle index and weekday remainder
	assign cy_prod = 33'(zp_s2) * 33'(RCP_1461);
	assign wk_full = days4_s2 - 16'(wq_s2) * 16'd7;

	// S4: day within the cycle
	assign r_full = zp_s3 - 16'(cyc_s3) * 16'd1461;

	// S5: year within the cycle, last year takes day 365
	assign yoc = 2'(r_s4 >= 11'd365) + 2'(r_s4 >= 11'd730) + 2'(r_s4 >= 11'd1095);
	assign doy_full = r_s4 - 11'(yoc) * 11'd365;

	// S6: March-based month index = (5*doy+2)/153
	assign mp_arg  = 11'(doy_s5) * 11'd5 + 11'd2;
	assign mp_prod = 23'(mp_arg) * 23'(RCP_153);

	// final: month, day and civil year (Jan and Feb belong to the next year)
	assign mday_full    = doy_s6 - month_start(mp_s6) + 9'd1;
	assign day_of_month = mday_full[MDAY_W-1:0];
	assign month        = (mp_s6 < 4'd10) ? mp_s6 + 4'd3 : mp_s6 - 4'd9;
	assign year         = ymar_s6 + 12'(mp_s6 >= 4'd10);

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			days4_s2 <= days4;
			wq_s2    <= wq_prod[31:19];
			zp_s2    <= zp_full;
		end
		if (ctl.ld[3]) begin
			zp_s3      <= zp_s2;
			cyc_s3     <= cy_prod[32:27];
			weekday_s3 <= wk_full[WDAY_W-1:0];
		end
		if (ctl.ld[4]) begin
			cyc_s4     <= cyc_s3;
			r_s4       <= r_full[10:0];
			weekday_s4 <= weekday_s3;
		end
		if (ctl.ld[5]) begin
			doy_s5     <= doy_full[8:0];
			ymar_s5    <= MAR_BASE_YR + {4'd0, cyc_s4, 2'b00} + 12'(yoc);
			weekday_s5 <= weekday_s4;
		end
		if (ctl.ld[6]) begin
			doy_s6     <= doy_s5;
			ymar_s6    <= ymar_s5;
			mp_s6      <= mp_prod[22:19];
			weekday_s6 <= weekday_s5;
		end
	end

endmodule

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Throughput: one word per cycle; each stage holds under stall, bubbles close.
// The seven-stage pipe (constant-reciprocal multipliers) sets this rate.
// Reset clears all valid bits and loads the year window with 2015..2025.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top
	import ecal_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SECS_W-1:0]    epoch_seconds,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [YEAR_W-1:0]    year,
	output logic [MONTH_W-1:0]   month,
	output logic [MDAY_W-1:0]    day_of_month,
	output logic [HOUR_W-1:0]    hour,
	output logic [MIN_W-1:0]     minute,
	output logic [SEC_W-1:0]     second,
	output logic [WDAY_W-1:0]    weekday,
	output logic [SOD_W-1:0]     second_of_day,
	output logic                 year_in_window,
	// configuration writes
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// Stage map
	//   S1  days = (secs/128)/675 by reciprocal multiply
	//   S2  second of day; weekday quotient; March-based day count
	//   S3  hour; four-year cycle index; weekday
	//   S4  seconds in hour; day within cycle
	//   S5  minute; year and day within the March-based year
	//   S6  second; month index
	//   S7  output register, civil date and year window flag

	ecal_ctl_t          ctl;
	logic               out_ld;
	logic [NUM_STG:1]   vld_q;
	logic               vld_s7;

	logic [YEAR_W-1:0]  yr_low_q, yr_high_q;

	logic [50:0]        days_prod;
	logic [SECS_W-1:0]  secs_s1;
	logic [DAYS_W-1:0]  days_s1;

	logic [SOD_W-1:0]   sod_s6;
	logic [HOUR_W-1:0]  hour_s6;
	logic [MIN_W-1:0]   minute_s6;
	logic [SEC_W-1:0]   second_s6;
	logic [YEAR_W-1:0]  year_c;
	logic [MONTH_W-1:0] month_c;
	logic [MDAY_W-1:0]  mday_c;
	logic [WDAY_W-1:0]  weekday_s6;

	logic [YEAR_W-1:0]  year_s7;
	logic [MONTH_W-1:0] month_s7;
	logic [MDAY_W-1:0]  mday_s7;
	logic [HOUR_W-1:0]  hour_s7;
	logic [MIN_W-1:0]   minute_s7;
	logic [SEC_W-1:0]   second_s7;
	logic [WDAY_W-1:0]  weekday_s7;
	logic [SOD_W-1:0]   sod_s7;
	logic               inwin_s7;

	// ---- flow control ---------------------------------------------------
	// A stage loads when it is empty or when the stage after it loads too,
	// so a stall only freezes the words stacked up behind the output.
	assign out_ld = !vld_s7 || !out_stall;

	always_comb begin
		ctl.ld[NUM_STG] = !vld_q[NUM_STG] || out_ld;
		for (int k = NUM_STG - 1; k >= 1; k--) begin
			ctl.ld[k] = !vld_q[k] || ctl.ld[k+1];
		end
	end

	assign in_stall = !ctl.ld[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s7 <= 1'b0;
		end else begin
			if (ctl.ld[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STG; k++) begin
				if (ctl.ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (out_ld) begin
				vld_s7 <= vld_q[NUM_STG];
			end
		end
	end

	// ---- configuration --------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yr_low_q  <= YEAR_LOW_RST;
			yr_high_q <= YEAR_HIGH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_YEAR_LOW:  yr_low_q  <= cfg_wdata;
				REG_YEAR_HIGH: yr_high_q <= cfg_wdata;
			endcase
		end
	end

	// ---- S1: whole days -------------------------------------------------
	// 86400 = 128 * 675; the reciprocal of 675 at 2^35 is exact for 25-bit x
	assign days_prod = 51'(epoch_seconds[31:7]) * 51'(RCP_675);

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			secs_s1 <= epoch_seconds;
			days_s1 <= days_prod[50:35];
		end
	end

	// ---- S2..S6: time of day and date lanes -----------------------------
	ecal_tod u_tod (
		.clk       (clk),
		.ctl       (ctl),
		.secs_s1   (secs_s1),
		.days_s1   (days_s1),
		.sod_s6    (sod_s6),
		.hour_s6   (hour_s6),
		.minute_s6 (minute_s6),
		.second_s6 (second_s6)
	);

	ecal_date u_date (
		.clk          (clk),
		.ctl          (ctl),
		.days_s1      (days_s1),
		.year         (year_c),
		.month        (month_c),
		.day_of_month (mday_c),
		.weekday_s6   (weekday_s6)
	);

	// ---- S7: output register --------------------------------------------
	// Window compares the registers as written; an inverted window flags none.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			year_s7    <= year_c;
			month_s7   <= month_c;
			mday_s7    <= mday_c;
			hour_s7    <= hour_s6;
			minute_s7  <= minute_s6;
			second_s7  <= second_s6;
			weekday_s7 <= weekday_s6;
			sod_s7     <= sod_s6;
			inwin_s7   <= (year_c >= yr_low_q) && (year_c <= yr_high_q);
		end
	end

	assign out_valid      = vld_s7;
	assign year           = year_s7;
	assign month          = month_s7;
	assign day_of_month   = mday_s7;
	assign hour           = hour_s7;
	assign minute         = minute_s7;
	assign second         = second_s7;
	assign weekday        = weekday_s7;
	assign second_of_day  = sod_s7;
	assign year_in_window = inwin_s7;

endmodule

// ===== rtl/ecal_checker.sv =====
// ----------------------------------------------------------------------------
// ecal_checker
// Port-level checks on the epoch-to-calendar block, bound to the top level.
// ----------------------------------------------------------------------------
module ecal_checker
	import ecal_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [YEAR_W-1:0]    year,
	input  logic [MONTH_W-1:0]   month,
	input  logic [MDAY_W-1:0]    day_of_month,
	input  logic [HOUR_W-1:0]    hour,
	input  logic [MIN_W-1:0]     minute,
	input  logic [SEC_W-1:0]     second,
	input  logic [WDAY_W-1:0]    weekday,
	input  logic [SOD_W-1:0]     second_of_day,
	input  logic                 year_in_window,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] lo_q, hi_q;
	logic             in_word;
	logic             out_word;
	logic [3:0]       flight_q;

	assign in_word  = in_valid && !in_stall;
	assign out_word = out_valid && !out_stall;

	// shadow of the window registers, seen from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= YEAR_LOW_RST;
			hi_q <= YEAR_HIGH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_YEAR_LOW:  lo_q <= cfg_wdata;
				REG_YEAR_HIGH: hi_q <= cfg_wdata;
			endcase
		end
	end

	// words accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else begin
			flight_q <= flight_q + 4'(in_word) - 4'(out_word);
		end
	end

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(year) && $stable(second_of_day)
			&& $stable(day_of_month))
		else $error("stalled result word changed");

	// time fields agree with the second of day
	a_tod_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second))
			== second_of_day && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
		else $error("time of day fields inconsistent");

	// date fields in range
	a_date_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& weekday <= 3'd6 && year >= 12'd1970 && year <= 12'd2106)
		else $error("date field out of range");

	// window flag follows the written registers
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year_in_window == ((year >= lo_q) && (year <= hi_q)))
		else $error("year window flag wrong");

	// a result word needs an input word ahead of it; seven stages hold at most seven
	a_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flight_q != 4'd0 && flight_q <= 4'd7)
		else $error("result word without a matching input word");

endmodule

bind epoch_seconds_to_calendar_top ecal_checker u_ecal_checker (.*);

// ===== tb/tb_epoch_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Drives Unix timestamps into the calendar pipeline and checks every result
// word against a behavioral date calculator kept inside the bench. Covers
// leap and century rules, day and year rollovers, the whole 32-bit range,
// and the year window under reset, extreme, empty and random settings.
// Both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top
	import ecal_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// expected content of one result word
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [MDAY_W-1:0]  day_of_month;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [WDAY_W-1:0]  weekday;
		logic [SOD_W-1:0]   second_of_day;
		logic               year_in_window;
	} cal_word_t;

	typedef struct packed {
		logic [SECS_W-1:0] secs;
		cal_word_t         want;
	} pending_date_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [SECS_W-1:0]    epoch_seconds;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [YEAR_W-1:0]    year;
	logic [MONTH_W-1:0]   month;
	logic [MDAY_W-1:0]    day_of_month;
	logic [HOUR_W-1:0]    hour;
	logic [MIN_W-1:0]     minute;
	logic [SEC_W-1:0]     second;
	logic [WDAY_W-1:0]    weekday;
	logic [SOD_W-1:0]     second_of_day;
	logic                 year_in_window;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// bench copy of the year window, follows every register write
	logic [CFG_W-1:0] win_lo = YEAR_LOW_RST;
	logic [CFG_W-1:0] win_hi = YEAR_HIGH_RST;

	// first day of month m (index 1..12) counted from Jan 1
	int unsigned cum_norm [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	int unsigned cum_leap [13] = '{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

	pending_date_t pending [$];

	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned window_writes = 0;

	// idling controls: quiet = no idling on that side, heavy = short stalls only, mostly open
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit rx_heavy = 1'b0;
	int unsigned rx_left = 0;

	epoch_seconds_to_calendar_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.epoch_seconds  (epoch_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.year           (year),
		.month          (month),
		.day_of_month   (day_of_month),
		.hour           (hour),
		.minute         (minute),
		.second         (second),
		.weekday        (weekday),
		.second_of_day  (second_of_day),
		.year_in_window (year_in_window),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// date arithmetic
	// ------------------------------------------------------------------
	function automatic bit is_leap_yr(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// days from 1970-01-01 to Jan 1 of year y, y >= 1970
	function automatic int unsigned days_to_jan1(input int unsigned y);
		int unsigned p;
		int unsigned d;
		p = y - 1;
		d = (y - 1970) * 365;
		d = d + (p / 4 - 1969 / 4);
		d = d - (p / 100 - 1969 / 100);
		d = d + (p / 400 - 1969 / 400);
		return d;
	endfunction

	// full expected result word for one timestamp under the current window
	function automatic cal_word_t calendar_of(input logic [SECS_W-1:0] secs);
		cal_word_t   w;
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned doy;
		int unsigned mo;
		int unsigned md;
		int unsigned start;
		int unsigned wy;
		int unsigned wm;
		bit          leap;
		bit          found;
		t = secs;
		w.second = SEC_W'(t % 60);
		t = t / 60;
		w.minute = MIN_W'(t % 60);
		t = t / 60;
		w.hour = HOUR_W'(t % 24);
		days = t / 24;

		// estimate from below, then walk forward until the day fits the year
		yr = 1970 + days / 366;
		forever begin
			doy = days - days_to_jan1(yr);
			leap = is_leap_yr(yr);
			if (doy < (leap ? 366 : 365))
				break;
			yr++;
		end

		// leap table only from Feb 29 on
		mo = 1;
		md = 1;
		found = 1'b0;
		for (int i = 12; i >= 1; i--) begin
			start = (leap && doy >= 59) ? cum_leap[i] : cum_norm[i];
			if (!found && doy >= start) begin
				mo = i;
				md = doy - start + 1;
				found = 1'b1;
			end
		end

		// Zeller-type weekday, Jan and Feb counted as months 13 and 14
		wy = yr;
		wm = mo;
		if (wm <= 2) begin
			wm = wm + 12;
			wy = wy - 1;
		end
		w.weekday = WDAY_W'((md + 1 + 2 * wm + (3 * (wm + 1)) / 5 + wy + wy / 4 + wy / 400
			- wy / 100) % 7);

		w.year = YEAR_W'(yr);
		w.month = MONTH_W'(mo);
		w.day_of_month = MDAY_W'(md);
		w.second_of_day = SOD_W'(secs % 86400);
		w.year_in_window = (yr >= win_lo) && (yr <= win_hi);
		return w;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// mostly no gap, often a short one, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// timestamps weighted toward year, month, day and window edges
	function automatic logic [SECS_W-1:0] random_epoch();
		longint      s;
		int unsigned y;
		int unsigned mo;
		int unsigned r;
		int          off;
		r = $urandom_range(0, 99);
		y = $urandom_range(1970, 2106);
		// a few seconds or up to two days either side of the chosen edge
		off = $urandom_range(0, 1) ? int'($urandom_range(0, 8)) - 4
			: int'($urandom_range(0, 4 * 86400)) - 2 * 86400;
		if (r < 30) begin
			s = longint'($urandom);
		end else if (r < 50) begin
			s = longint'(days_to_jan1(y)) * 86400 + off;
		end else if (r < 70) begin
			mo = $urandom_range(1, 12);
			s = longint'(days_to_jan1(y) + (is_leap_yr(y) ? cum_leap[mo] : cum_norm[mo]))
				* 86400 + off;
		end else if (r < 85) begin
			s = longint'($urandom_range(0, 49710)) * 86400
				+ ($urandom_range(0, 1) ? $urandom_range(0, 5) : 86399 - $urandom_range(0, 5));
		end else begin
			y = $urandom_range(0, 1) ? 32'(win_lo) : 32'(win_hi) + 1;
			if (y < 1970)
				y = 1970;
			if (y > 2107)
				y = 2107;
			s = longint'(days_to_jan1(y)) * 86400 + off;
		end
		return s[SECS_W-1:0];
	endfunction

	// one input word, with a random gap ahead of it; the expectation is
	// queued at the edge that accepts the word
	task automatic send_epoch(input logic [SECS_W-1:0] secs);
		int unsigned gap;
		pending_date_t p;
		gap = tx_quiet ? 0 : idle_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		epoch_seconds = secs;
		do
			@(posedge clk);
		while (in_stall);
		p.secs = secs;
		p.want = calendar_of(secs);
		pending.push_back(p);
		items_sent++;
	endtask

	// stop sending and wait for every outstanding result word
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	// every word yields a result, so the pipe is empty once drained
	task automatic set_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		wait_drained();
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = REG_YEAR_LOW;
		cfg_wdata = lo;
		@(negedge clk);
		cfg_index = REG_YEAR_HIGH;
		cfg_wdata = hi;
		@(negedge clk);
		cfg_wen = 1'b0;
		win_lo = lo;
		win_hi = hi;
		window_writes++;
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("[%0t] MISMATCH %s", $time, what);
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned want, input logic [SECS_W-1:0] secs);
		if (got != want)
			report_mismatch($sformatf("%s for epoch %0d: got %0d, want %0d",
				name, secs, got, want));
	endtask

	always @(posedge clk) begin : result_check
		pending_date_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				e = pending.pop_front();
				check_field("year", 32'(year), 32'(e.want.year), e.secs);
				check_field("month", 32'(month), 32'(e.want.month), e.secs);
				check_field("day_of_month", 32'(day_of_month), 32'(e.want.day_of_month),
					e.secs);
				check_field("hour", 32'(hour), 32'(e.want.hour), e.secs);
				check_field("minute", 32'(minute), 32'(e.want.minute), e.secs);
				check_field("second", 32'(second), 32'(e.want.second), e.secs);
				check_field("weekday", 32'(weekday), 32'(e.want.weekday), e.secs);
				check_field("second_of_day", 32'(second_of_day), 32'(e.want.second_of_day),
					e.secs);
				check_field("year_in_window", 32'(year_in_window),
					32'(e.want.year_in_window), e.secs);
			end
		end
	end

	// receiver: runs of open and stalled cycles, changed on the falling edge
	always @(negedge clk) begin : rx_pacing
		int unsigned r;
		if (rx_quiet) begin
			out_stall = 1'b0;
			rx_left = 0;
		end else if (rx_left != 0) begin
			rx_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (rx_heavy)
				r = r / 4 + 40;
			if (r < 55) begin
				out_stall = 1'b0;
				rx_left = $urandom_range(0, 6);
			end else if (r < 92) begin
				out_stall = 1'b1;
				rx_left = $urandom_range(0, 2);
			end else begin
				out_stall = 1'b1;
				rx_left = $urandom_range(8, 40);
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// landmark dates under the reset window of 2015..2025
	task automatic test_landmark_dates();
		logic [SECS_W-1:0] landmark_secs [24];
		landmark_secs = '{
			32'd0,          32'd86399,                       // first day of the epoch
			32'd68169599,   32'd68169600,                    // 1972: Feb 28 -> Feb 29
			32'd68255999,   32'd68256000,                    // 1972: Feb 29 -> Mar 1
			32'd94694399,                                    // last day of a leap year
			32'd946684799,  32'd946684800,                   // into 2000
			32'd951868799,  32'd951868800,                   // 2000 is leap (div by 400)
			32'd1420070399, 32'd1420070400,                  // reset window low edge
			32'd1767225599, 32'd1767225600,                  // reset window high edge
			32'h7FFFFFFF,   32'h80000000,                    // signed 32-bit rollover
			32'd4107542399, 32'd4107542400,                  // 2100 is not leap
			32'd4291747199, 32'd4291747200,                  // into 2106
			32'h55555555,   32'hAAAAAAAA,
			32'hFFFFFFFF                                     // last representable second
		};
		foreach (landmark_secs[i])
			send_epoch(landmark_secs[i]);
	endtask

	// random dates over the whole reachable window, with no-idle stretches
	task automatic test_random_dates();
		set_window(12'd1970, 12'd2106);
		for (int blk = 0; blk < 5; blk++) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			repeat (100)
				send_epoch(random_epoch());
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// year window: extremes, empty, single year, out-of-range and random
	task automatic test_window_settings();
		logic [CFG_W-1:0] lo_set [10];
		logic [CFG_W-1:0] hi_set [10];
		lo_set = '{12'd2050, 12'd0,    12'd4095, 12'd2038, 12'd2106, 12'd1970,
			12'hAAA, 12'd1969, 12'd0, 12'd0};
		hi_set = '{12'd2000, 12'd4095, 12'd0,    12'd2038, 12'd2106, 12'd1970,
			12'h555, 12'd2107, 12'd0, 12'd0};
		// last two settings drawn at random, partly outside the reachable years
		lo_set[8] = CFG_W'($urandom_range(1960, 2115));
		hi_set[8] = CFG_W'($urandom_range(1960, 2115));
		lo_set[9] = CFG_W'($urandom_range(1970, 2040));
		hi_set[9] = CFG_W'($urandom_range(2040, 2106));
		foreach (lo_set[i]) begin
			set_window(lo_set[i], hi_set[i]);
			repeat (100)
				send_epoch(random_epoch());
		end
	endtask

	// short output stalls only, with a full-rate sender, a pause until drained,
	// then a stretch with no idling on either side
	task automatic test_back_pressure();
		set_window(12'd2000, 12'd2050);
		tx_quiet = 1'b1;
		rx_heavy = 1'b1;
		repeat (100)
			send_epoch(random_epoch());
		wait_drained();
		rx_heavy = 1'b0;
		rx_quiet = 1'b1;
		repeat (100)
			send_epoch(random_epoch());
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		cfg_wen = 1'b0;
		cfg_index = REG_YEAR_LOW;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_landmark_dates();
		test_random_dates();
		test_window_settings();
		test_back_pressure();

		// final drain, bounded, then a further wait to catch stray words
		@(negedge clk);
		in_valid = 1'b0;
		for (int n = 0; n < 20000 && pending.size() != 0; n++)
			@(posedge clk);
		repeat (NUM_STG + 4) @(posedge clk);
		if (pending.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived", pending.size()));

		$display("dates sent: %0d, result words checked: %0d, year windows written: %0d",
			items_sent, results_seen, window_writes);
		$display("leap/century rules, rollovers, full 32-bit range, empty and extreme windows");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, well past the slowest legal run
	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
